>>> rtl/gsp_pkg.sv
// ----------------------------------------------------------------------------
// gsp_pkg
// Shared types, register map and gain schedule for the gain-scheduled
// steering servo PD controller.
// ----------------------------------------------------------------------------
package gsp_pkg;

   // register map, index = paddr[4:2]
   typedef enum logic [2:0] {
      REG_CENTER_DUTY = 3'd0,
      REG_UPPER_LIMIT = 3'd1,
      REG_LOWER_LIMIT = 3'd2,
      REG_DERIV_GAIN  = 3'd3,
      REG_DIFF_GAIN   = 3'd4,
      REG_DEAD_BAND   = 3'd5
   } reg_index_type;

   localparam logic [15:0] CENTER_DUTY_RST = 16'd4500;
   localparam logic [15:0] UPPER_LIMIT_RST = 16'd5600;
   localparam logic [15:0] LOWER_LIMIT_RST = 16'd3400;
   localparam logic [7:0]  DERIV_GAIN_RST  = 8'd50;
   localparam logic [7:0]  DIFF_GAIN_RST   = 8'd0;
   localparam logic [6:0]  DEAD_BAND_RST   = 7'd2;

   // gain schedule
   localparam int TABLE_ENTRIES = 22;
   localparam int TABLE_STORED  = 22;
   localparam logic [7:0] BAND_LOW_MAX  = 8'd40;
   localparam logic [7:0] BAND_MID_END  = 8'd50;
   localparam logic [4:0] GAIN_BAND_LOW = 5'd18;
   localparam logic [4:0] GAIN_BAND_MID = 5'd22;
   localparam logic [4:0] GAIN_BAND_TOP = 5'd25;

   typedef logic [4:0] gain_type;

   localparam gain_type GAIN_TABLE [TABLE_STORED] = '{
      5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd4, 5'd5, 5'd5, 5'd5, 5'd5,
      5'd6, 5'd6, 5'd6, 5'd6, 5'd7, 5'd7, 5'd8, 5'd8, 5'd9, 5'd9,
      5'd10, 5'd10
   };

   // proportional gain from error magnitude (0..128)
   function automatic gain_type pick_gain(input logic [7:0] mag);
      gain_type g;
      if ((32'(mag) < TABLE_ENTRIES) && (32'(mag) < TABLE_STORED)) begin
         g = GAIN_TABLE[mag[4:0]];
      end else if (mag <= BAND_LOW_MAX) begin
         g = GAIN_BAND_LOW;
      end else if (mag < BAND_MID_END) begin
         g = GAIN_BAND_MID;
      end else begin
         g = GAIN_BAND_TOP;
      end
      return g;
   endfunction

endpackage

>>> rtl/gain_scheduled_servo_pd.sv
// ----------------------------------------------------------------------------
// gain_scheduled_servo_pd
// Gain-scheduled PD steering servo controller with APB register port.
// ----------------------------------------------------------------------------
// Usage:
//   req_ channel carries one signed steering error word per control period.
//   rsp_ channel returns one word per request: the clamped duty and the
//   proportional gain picked from the error magnitude.
//   From request accept to rsp_valid a word passes the input register
//   (error plus the two previous errors), then gain pick, three small
//   multiplies, sum and clamp into the result register.
//   Throughput is one word per cycle while rsp_ready stays high; the
//   input register and the result register form a two-stage pipeline,
//   so a new word is taken while a finished result waits. If rsp_ready
//   stays low, the pipeline fills and req_ready drops after two words.
//   The error history shifts on every accepted word, deadband or not.
//   Reset (synchronous) empties the pipeline, clears the error history and
//   loads the register defaults. Registers are written over APB
//   (psel, penable, pwrite, pready all high); pready is tied high. Change
//   registers only while no word is in flight.
// ----------------------------------------------------------------------------
module gain_scheduled_servo_pd (
   input  logic        clock,
   input  logic        reset,
   // request
   input  logic        req_valid,
   output logic        req_ready,
   input  logic signed [7:0] req_steer_error,
   // response
   output logic        rsp_valid,
   input  logic        rsp_ready,
   output logic [15:0] rsp_duty,
   output logic [4:0]  rsp_gain_used,
   // APB registers
   input  logic        psel,
   input  logic        penable,
   input  logic        pwrite,
   input  logic [4:0]  paddr,
   input  logic [31:0] pwdata,
   output logic [31:0] prdata,
   output logic        pready
);

   // registers
   logic [15:0] center_duty_ff;
   logic [15:0] upper_limit_ff;
   logic [15:0] lower_limit_ff;
   logic [7:0]  deriv_gain_ff;
   logic [7:0]  diff_gain_ff;
   logic [6:0]  dead_band_ff;

   logic        csr_write;
   logic [2:0]  csr_index;

   assign pready    = 1'b1;
   assign csr_write = psel & penable & pwrite & pready;
   assign csr_index = paddr[4:2];

   always_ff @(posedge clock) begin
      if (reset) begin
         center_duty_ff <= gsp_pkg::CENTER_DUTY_RST;
         upper_limit_ff <= gsp_pkg::UPPER_LIMIT_RST;
         lower_limit_ff <= gsp_pkg::LOWER_LIMIT_RST;
         deriv_gain_ff  <= gsp_pkg::DERIV_GAIN_RST;
         diff_gain_ff   <= gsp_pkg::DIFF_GAIN_RST;
         dead_band_ff   <= gsp_pkg::DEAD_BAND_RST;
      end else if (csr_write) begin
         case (csr_index)
            gsp_pkg::REG_CENTER_DUTY: center_duty_ff <= pwdata[15:0];
            gsp_pkg::REG_UPPER_LIMIT: upper_limit_ff <= pwdata[15:0];
            gsp_pkg::REG_LOWER_LIMIT: lower_limit_ff <= pwdata[15:0];
            gsp_pkg::REG_DERIV_GAIN:  deriv_gain_ff  <= pwdata[7:0];
            gsp_pkg::REG_DIFF_GAIN:   diff_gain_ff   <= pwdata[7:0];
            gsp_pkg::REG_DEAD_BAND:   dead_band_ff   <= pwdata[6:0];
            default: ;
         endcase
      end
   end

   always_comb begin
      case (csr_index)
         gsp_pkg::REG_CENTER_DUTY: prdata = {16'd0, center_duty_ff};
         gsp_pkg::REG_UPPER_LIMIT: prdata = {16'd0, upper_limit_ff};
         gsp_pkg::REG_LOWER_LIMIT: prdata = {16'd0, lower_limit_ff};
         gsp_pkg::REG_DERIV_GAIN:  prdata = {24'd0, deriv_gain_ff};
         gsp_pkg::REG_DIFF_GAIN:   prdata = {24'd0, diff_gain_ff};
         gsp_pkg::REG_DEAD_BAND:   prdata = {25'd0, dead_band_ff};
         default:                  prdata = 32'd0;
      endcase
   end

   // pipeline control
   logic s1_vld_ff, s1_vld_in;
   logic rsp_vld_ff, rsp_vld_in;
   logic req_take, s1_move;

   assign s1_move   = s1_vld_ff & (~rsp_vld_ff | rsp_ready);
   assign req_ready = ~s1_vld_ff | s1_move;
   assign req_take  = req_valid & req_ready;
   assign s1_vld_in  = req_take | (s1_vld_ff & ~s1_move);
   assign rsp_vld_in = s1_move | (rsp_vld_ff & ~rsp_ready);

   // error history
   logic signed [7:0] prev_error_ff;
   logic signed [7:0] prev_prev_error_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_vld_ff          <= 1'b0;
         rsp_vld_ff         <= 1'b0;
         prev_error_ff      <= '0;
         prev_prev_error_ff <= '0;
      end else begin
         s1_vld_ff  <= s1_vld_in;
         rsp_vld_ff <= rsp_vld_in;
         if (req_take) begin
            prev_error_ff      <= req_steer_error;
            prev_prev_error_ff <= prev_error_ff;
         end
      end
   end

   // input register: e, e1, e2
   logic signed [7:0] e_ff, e1_ff, e2_ff;

   always_ff @(posedge clock) begin
      if (req_take) begin
         e_ff  <= req_steer_error;
         e1_ff <= prev_error_ff;
         e2_ff <= prev_prev_error_ff;
      end
   end

   // gain pick, PD sum and clamp
   logic [7:0]          mag;
   gsp_pkg::gain_type   gain;
   logic signed [8:0]   d1;
   logic signed [9:0]   d2;
   logic signed [13:0]  p_term;
   logic signed [17:0]  i_term;
   logic signed [18:0]  d_term;
   logic signed [19:0]  center_s, upper_s, lower_s, sum;
   logic [15:0]         duty_in;

   always_comb begin
      mag  = e_ff[7] ? 8'(-{1'b1, e_ff}) : 8'(e_ff);
      gain = gsp_pkg::pick_gain(mag);
      d1   = 9'(e_ff) - 9'(e1_ff);
      d2   = 10'(e_ff) - (10'(e1_ff) <<< 1) + 10'(e2_ff);
      p_term = $signed({1'b0, gain}) * 14'(e_ff);
      i_term = $signed({1'b0, diff_gain_ff}) * 18'(d1);
      d_term = $signed({1'b0, deriv_gain_ff}) * 19'(d2);
      center_s = $signed({4'd0, center_duty_ff});
      upper_s  = $signed({4'd0, upper_limit_ff});
      lower_s  = $signed({4'd0, lower_limit_ff});
      if (mag <= {1'b0, dead_band_ff}) begin
         sum = center_s;
      end else begin
         sum = center_s + 20'(p_term) + 20'(i_term) + 20'(d_term);
      end
      // upper test first so crossed limits resolve to upper
      if (sum >= upper_s) begin
         duty_in = upper_limit_ff;
      end else if (sum <= lower_s) begin
         duty_in = lower_limit_ff;
      end else begin
         duty_in = sum[15:0];
      end
   end

   // result register
   logic [15:0]       duty_ff;
   gsp_pkg::gain_type gain_ff;

   always_ff @(posedge clock) begin
      if (s1_move) begin
         duty_ff <= duty_in;
         gain_ff <= gain;
      end
   end

   assign rsp_valid     = rsp_vld_ff;
   assign rsp_duty      = duty_ff;
   assign rsp_gain_used = gain_ff;

   // checks
   a_hist_shift: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> prev_prev_error_ff == $past(prev_error_ff))
      else $error("error history did not shift");

   a_fill: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> s1_vld_ff)
      else $error("accepted word lost from input stage");

   a_gain_range: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_gain_used <= gsp_pkg::GAIN_BAND_TOP)
      else $error("gain out of schedule range");

   a_duty_clamp: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_duty == upper_limit_ff || rsp_duty == lower_limit_ff ||
                     (rsp_duty > lower_limit_ff && rsp_duty < upper_limit_ff)))
      else $error("duty outside limits");

endmodule
